### rtl/scaled_glyph_text_rasterizer_defines.svh
// assertion macros shared by the glyph rasterizer rtl
// no dependencies; included by the modules that carry assertions
`ifndef SCALED_GLYPH_TEXT_RASTERIZER_DEFINES_SVH
`define SCALED_GLYPH_TEXT_RASTERIZER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SGTR_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SGTR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sgtr_pkg.sv
// shared types, constants and the 5x7 font for the glyph rasterizer
// no dependencies
`default_nettype none

package sgtr_pkg;

  localparam int GLYPH_W       = 5;
  localparam int GLYPH_H       = 7;
  localparam int SC_W          = 4;   // holds a scale up to 15
  localparam int MASK_W        = 20;
  localparam int Y_W           = 13;
  localparam int FB_WIDTH_DEF  = 1024;
  localparam int FB_HEIGHT_DEF = 1024;
  localparam int MAX_SCALE_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic signed [11:0] CURSOR_TOP = 12'sd2047;

  typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

  typedef struct packed {
    glyph_t                              glyph;
    logic signed [11:0]                  x0;
    logic signed [11:0]                  y0;
    logic signed [Y_W-1:0]               y_last;
    logic [SC_W-1:0]                     sc;
    logic [0:GLYPH_W-1][MASK_W-1:0]      col_mask;
    logic [23:0]                         color;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // character byte to glyph rows, top row first; unknown codes are blank
  function automatic glyph_t glyph_rows(input logic [7:0] code);
    glyph_t g;
    case (code)
      "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      "6": g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      "%": g = {5'h11, 5'h0A, 5'h04, 5'h0E, 5'h11, 5'h0A, 5'h00};
      "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "M": g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "W": g = {5'h11, 5'h11, 5'h15, 5'h15, 5'h0A, 5'h0A, 5'h00};
      "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "!": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
      "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "c": g = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h11, 5'h0E};
      "e": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
      "l": g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "s": g = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h0E, 5'h01, 5'h1E};
      "r": g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      "a": g = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
      "y": g = {5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      "d": g = {5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F};
      "i": g = {5'h00, 5'h04, 5'h00, 5'h04, 5'h04, 5'h04, 5'h0E};
      "n": g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
      "w": g = {5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A, 5'h00};
      "p": g = {5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10};
      "k": g = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
      "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "f": g = {5'h06, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h08};
      "o": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      "m": g = {5'h00, 5'h00, 5'h1B, 5'h15, 5'h15, 5'h15, 5'h15};
      "v": g = {5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h00};
      "u": g = {5'h00, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0F};
      "x": g = {5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h00};
      "t": g = {5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h03};
      "g": g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
      "h": g = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
      "b": g = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      "z": g = {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      "q": g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h00};
      "j": g = {5'h00, 5'h02, 5'h00, 5'h02, 5'h02, 5'h12, 5'h0C};
      "D": g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "X": g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11};
      "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "J": g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      default: g = '0;   // space and every unsupported code
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/sgtr_front.sv
// front end: owns the text cursor, looks up the glyph, clamps the scale,
// works out the row range and per-column masks; depends on sgtr_pkg
`default_nettype none

module sgtr_front
  import sgtr_pkg::*;
#(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF,
  parameter int MAX_SCALE = MAX_SCALE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         char_code,
  input  wire logic               set_cursor,
  input  wire logic signed [11:0] pos_x,
  input  wire logic signed [11:0] pos_y,
  input  wire logic [2:0]         scale,
  input  wire logic [23:0]        color,
  output cmd_t                    cmd,
  output logic                    cmd_push
);

  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(FB_HEIGHT - 1);
  localparam logic signed [12:0]    X_LIM = 13'(FB_WIDTH);
  localparam logic [SC_W-1:0]       SC_MAX = SC_W'(MAX_SCALE);

  logic signed [11:0]    cursor_x;
  logic signed [11:0]    cursor_y;
  logic signed [11:0]    base_x;
  logic signed [11:0]    base_y;
  logic [SC_W-1:0]       sc;
  logic [6:0]            adv;
  logic [6:0]            height;
  logic signed [12:0]    x_sum;
  logic signed [Y_W-1:0] y_top;
  logic signed [Y_W-1:0] y_end;
  logic [MASK_W-1:0]     clip;
  logic                  any_row;

  assign base_x = set_cursor ? pos_x : cursor_x;
  assign base_y = set_cursor ? pos_y : cursor_y;
  assign sc     = ({1'b0, scale} > SC_MAX) ? SC_MAX : {1'b0, scale};

  // six cells of advance and seven cells of height
  assign adv    = {2'b0, sc, 1'b0} + {1'b0, sc, 2'b0};
  assign height = {sc, 3'b0} - {3'b0, sc};

  assign x_sum  = $signed({base_x[11], base_x}) + $signed({6'b0, adv});
  assign y_top  = $signed({base_y[11], base_y});
  assign y_end  = y_top + $signed({6'b0, height}) - 13'sd1;

  assign any_row  = (sc != '0) && !y_end[Y_W-1] && (y_top <= Y_MAX);
  assign cmd_push = accept && any_row;

  always_comb begin
    logic signed [12:0] px;
    logic [5:0]         lo;
    logic [5:0]         hi;
    for (int i = 0; i < MASK_W; i++) begin
      px      = $signed({base_x[11], base_x}) + $signed(13'(i));
      clip[i] = !px[12] && (px < X_LIM);
    end
    cmd.glyph  = glyph_rows(char_code);
    cmd.x0     = base_x;
    cmd.y0     = base_y;
    cmd.y_last = (y_end > Y_MAX) ? Y_MAX : y_end;
    cmd.sc     = sc;
    cmd.color  = color;
    // bits i with i / sc == c, limited to the visible columns
    for (int c = 0; c < GLYPH_W; c++) begin
      lo = 6'(c) * {2'b0, sc};
      hi = lo + {2'b0, sc};
      for (int i = 0; i < MASK_W; i++) begin
        cmd.col_mask[c][i] = (6'(i) >= lo) && (6'(i) < hi) && clip[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (accept) begin
      cursor_x <= (x_sum > 13'sd2047) ? CURSOR_TOP : x_sum[11:0];
      cursor_y <= base_y;
    end
  end

endmodule

`default_nettype wire

### rtl/sgtr_cmd_queue.sv
// short command queue between the front and back ends
// depends on sgtr_pkg and the shared assertion macros
`default_nettype none
`include "scaled_glyph_text_rasterizer_defines.svh"

module sgtr_cmd_queue
  import sgtr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire cmd_t    push_cmd,
  input  wire logic    pop,
  output cmd_t         head,
  output queue_status_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SGTR_ASSERT_IMPL(a_push_not_full, clk, rst, push, !stat.full, "command pushed into a full queue")
  `SGTR_ASSERT_IMPL(a_pop_not_empty, clk, rst, pop, !stat.empty, "command popped from an empty queue")
  `SGTR_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

### rtl/sgtr_back.sv
// back end: walks the queued character's destination rows one per cycle
// unless the reader stalls; fills the result register; depends on sgtr_pkg and macros
`default_nettype none
`include "scaled_glyph_text_rasterizer_defines.svh"

module sgtr_back
  import sgtr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmd_t          head,
  input  wire queue_status_t q_stat,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [9:0]         row,
  output logic signed [11:0] x_start,
  output logic [MASK_W-1:0]  pixel_mask,
  output logic [23:0]        pixel_color,
  output logic               last
);

  logic                  active;
  logic signed [Y_W-1:0] y;
  logic [2:0]            r;
  logic [SC_W-1:0]       s;
  logic                  out_valid;
  logic                  on_screen;
  logic                  out_free;
  logic                  step;
  logic                  emit;
  logic                  at_last;
  logic                  start;
  logic [GLYPH_W-1:0]    row_bits;
  logic [MASK_W-1:0]     mask;

  // rows above the top edge are walked without output
  assign on_screen = !y[Y_W-1];
  assign out_free  = !out_valid || pop;
  assign step      = active && (!on_screen || out_free);
  assign emit      = step && on_screen;
  assign at_last   = (y == head.y_last);
  assign q_pop     = step && at_last;
  assign start     = !active && !q_stat.empty;
  assign empty     = !out_valid;
  assign row_bits  = head.glyph[r];

  always_comb begin
    mask = '0;
    for (int c = 0; c < GLYPH_W; c++) begin
      if (row_bits[GLYPH_W-1-c]) begin
        mask = mask | head.col_mask[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
        y      <= $signed({head.y0[11], head.y0});
        r      <= '0;
        s      <= '0;
      end else if (step) begin
        if (at_last) begin
          active <= 1'b0;
        end else begin
          y <= y + 1'b1;
          if (s == head.sc - 1'b1) begin
            s <= '0;
            r <= r + 3'd1;
          end else begin
            s <= s + 1'b1;
          end
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row         <= y[9:0];
      x_start     <= head.x0;
      pixel_mask  <= mask;
      pixel_color <= head.color;
      last        <= at_last;
    end
  end

  `SGTR_ASSERT_IMPL(a_row_in_glyph, clk, rst, active, r <= 3'd6, "glyph row index ran past the glyph")
  `SGTR_ASSERT_IMPL(a_sub_below_scale, clk, rst, active, s < head.sc, "sub-row count reached the scale")
  `SGTR_ASSERT_NEXT(a_last_ends, clk, rst, q_pop, !active, "walk kept going after the last row")

endmodule

`default_nettype wire

### rtl/scaled_glyph_text_rasterizer.sv
// top level of the scaled 5x7 glyph rasterizer
// depends on sgtr_pkg, sgtr_front, sgtr_cmd_queue and sgtr_back
//
// usage: each request is one character (char_code, set_cursor, pos_x, pos_y,
// scale, color) written with push while full is low. the block answers with
// one row-span write (row, x_start, pixel_mask, pixel_color, last) for every
// destination row of the scaled glyph that lies on the framebuffer, top row
// first, last set on the final one. results are read queue style: read the
// ports while empty is low, pulse pop to take one.
// a character whose rows all lie above or below the framebuffer, or that has
// scale 0, gives no result but still moves the cursor (by six cells of the
// clamped scale, saturating). timing: the back end walks one destination row
// per cycle while the reader keeps up; rows above the top edge are walked
// without output. a request's first write passes the command queue, the walk
// state and the result register before it shows. a two-entry command queue
// lets new characters be taken while rows are still being written; when the
// reader stalls the walk holds and full rises once the queue fills.
// reset clears the cursor to (0, 0) and drops all queued work and results.
`default_nettype none

module scaled_glyph_text_rasterizer
  import sgtr_pkg::*;
#(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF,
  parameter int MAX_SCALE = MAX_SCALE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         char_code,
  input  wire logic               set_cursor,
  input  wire logic signed [11:0] pos_x,
  input  wire logic signed [11:0] pos_y,
  input  wire logic [2:0]         scale,
  input  wire logic [23:0]        color,
  output logic                    empty,
  input  wire logic               pop,
  output logic [9:0]              row,
  output logic signed [11:0]      x_start,
  output logic [MASK_W-1:0]       pixel_mask,
  output logic [23:0]             pixel_color,
  output logic                    last
);

  cmd_t          front_cmd;
  cmd_t          head;
  queue_status_t q_stat;
  logic          accept;
  logic          cmd_push;
  logic          q_pop;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  sgtr_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_code  (char_code),
    .set_cursor (set_cursor),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .scale      (scale),
    .color      (color),
    .cmd        (front_cmd),
    .cmd_push   (cmd_push)
  );

  sgtr_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  sgtr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .row         (row),
    .x_start     (x_start),
    .pixel_mask  (pixel_mask),
    .pixel_color (pixel_color),
    .last        (last)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for scaled_glyph_text_rasterizer: queue-style push/pop traffic
// with bursty requests and random pop stalls, each row write checked against a local model
// depends on sgtr_pkg and the rasterizer rtl
`default_nettype none

module tb_top
  import sgtr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT     = 800000;
  localparam int RANDOM_CHARS  = 448;
  localparam int GLYPHS        = 66;
  localparam int BLANK_INDEX   = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP     = 100;

  // glyph characters in font order, first char in the top byte
  localparam logic [GLYPHS*8-1:0] GLYPH_CHARS =
    "0123456789 :%SPLAHMEWINRC!GOVTcelsraydinwpkFfomvuxtghbzqjDBKUXYZJQ";

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [7:0]         code;
    logic               set_cur;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [2:0]         scale;
    logic [23:0]        rgb;
    bit                 drain_first;
  } char_req_t;

  typedef struct {
    logic [9:0]         row;
    logic signed [11:0] xs;
    logic [MASK_W-1:0]  mask;
    logic [23:0]        rgb;
    logic               last;
  } row_write_t;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] char_code = '0;
  logic set_cursor = 1'b0;
  logic signed [11:0] pos_x = '0;
  logic signed [11:0] pos_y = '0;
  logic [2:0] scale = '0;
  logic [23:0] color = '0;
  logic empty;
  logic pop = 1'b0;
  logic [9:0] row;
  logic signed [11:0] x_start;
  logic [MASK_W-1:0] pixel_mask;
  logic [23:0] pixel_color;
  logic last;

  char_req_t  char_q[$];
  row_write_t row_writes_due[$];

  int cur_x = 0;
  int cur_y = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  int n_rows = 0;
  int n_bad = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  logic [7:0] rx_pattern = 8'b1101_0010;

  scaled_glyph_text_rasterizer dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_code  (char_code),
    .set_cursor (set_cursor),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .scale      (scale),
    .color      (color),
    .empty      (empty),
    .pop        (pop),
    .row        (row),
    .x_start    (x_start),
    .pixel_mask (pixel_mask),
    .pixel_color(pixel_color),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] glyph_char(input int idx);
    return GLYPH_CHARS[(GLYPHS-1-idx)*8 +: 8];
  endfunction

  function automatic int glyph_index(input logic [7:0] code);
    for (int i = 0; i < GLYPHS; i++)
      if (glyph_char(i) == code) return i;
    return BLANK_INDEX;
  endfunction

  // seven row bytes per glyph, top row in the high byte
  function automatic logic [55:0] font_rows(input int idx);
    case (idx)
      0:  return 56'h0E11131519110E;  1:  return 56'h040C040404040E;
      2:  return 56'h0E11010204081F;  3:  return 56'h1F02040201110E;
      4:  return 56'h02060A121F0202;  5:  return 56'h1F101E0101110E;
      6:  return 56'h0608101E11110E;  7:  return 56'h1F010204080808;
      8:  return 56'h0E11110E11110E;  9:  return 56'h0E11110F01020C;
      10: return 56'h00000000000000;  11: return 56'h00040400040400;
      12: return 56'h110A040E110A00;  13: return 56'h0F10100E01011E;
      14: return 56'h1E11111E101010;  15: return 56'h1010101010101F;
      16: return 56'h0E11111F111111;  17: return 56'h1111111F111111;
      18: return 56'h111B1511111111;  19: return 56'h1F10101E10101F;
      20: return 56'h111115150A0A00;  21: return 56'h0E04040404040E;
      22: return 56'h11191513111111;  23: return 56'h1E11111E141211;
      24: return 56'h0E11101010110E;  25: return 56'h04040404040004;
      26: return 56'h0E11101711110F;  27: return 56'h0E11111111110E;
      28: return 56'h111111110A0A04;  29: return 56'h1F040404040404;
      30: return 56'h00000E1010110E;  31: return 56'h00000E111F100E;
      32: return 56'h0C04040404040E;  33: return 56'h00000E100E011E;
      34: return 56'h00001619101010;  35: return 56'h00000E010F110F;
      36: return 56'h0011110F01010E;  37: return 56'h01010F1111110F;
      38: return 56'h0004000404040E;  39: return 56'h00001619111111;
      40: return 56'h00111115150A00;  41: return 56'h001E11111E1010;
      42: return 56'h10101214181412;  43: return 56'h1F10101E101010;
      44: return 56'h06081C08080808;  45: return 56'h00000E1111110E;
      46: return 56'h00001B15151515;  47: return 56'h001111110A0400;
      48: return 56'h0011111111110F;  49: return 56'h00110A040A1100;
      50: return 56'h04041F04040403;  51: return 56'h000F11110F010E;
      52: return 56'h10101619111111;  53: return 56'h10101E1111111E;
      54: return 56'h00001F0204081F;  55: return 56'h000F11110F0100;
      56: return 56'h0002000202120C;  57: return 56'h1C12111111121C;
      58: return 56'h1E11111E11111E;  59: return 56'h11121418141211;
      60: return 56'h1111111111110E;  61: return 56'h110A0404040A11;
      62: return 56'h11110A04040404;  63: return 56'h1F01020408101F;
      64: return 56'h0702020202120C;  65: return 56'h0E11111115120D;
      default: return '0;
    endcase
  endfunction

  // expected row writes of one character, cursor moved afterwards
  function automatic void rasterize_char(input char_req_t c);
    int sc, n, col, px, y;
    logic [55:0] rows;
    logic [4:0] bits;
    logic [MASK_W-1:0] mask;
    row_write_t w;
    if (c.set_cur) begin
      cur_x = c.px;
      cur_y = c.py;
    end
    sc = (c.scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : int'(c.scale);
    rows = font_rows(glyph_index(c.code));
    n = 0;
    for (int r = 0; r < GLYPH_H; r++) begin
      bits = rows[(GLYPH_H-1-r)*8 +: 5];
      mask = '0;
      for (int i = 0; i < GLYPH_W*sc; i++) begin
        col = i / sc;
        px = cur_x + i;
        if (bits[GLYPH_W-1-col] && px >= 0 && px < FB_WIDTH_DEF) mask[i] = 1'b1;
      end
      for (int s = 0; s < sc; s++) begin
        y = cur_y + r*sc + s;
        if (y >= 0 && y < FB_HEIGHT_DEF) begin
          w.row  = y[9:0];
          w.xs   = cur_x[11:0];
          w.mask = mask;
          w.rgb  = c.rgb;
          w.last = 1'b0;
          row_writes_due.push_back(w);
          n++;
        end
      end
    end
    if (n > 0) row_writes_due[row_writes_due.size()-1].last = 1'b1;
    cur_x += (GLYPH_W + 1) * sc;
    if (cur_x > int'(CURSOR_TOP)) cur_x = int'(CURSOR_TOP);
  endfunction

  function automatic void add_char(input logic [7:0] code, input logic set_cur, input int x,
                                   input int y, input int sc, input logic [23:0] rgb,
                                   input bit drain);
    char_req_t c;
    c.code        = code;
    c.set_cur     = set_cur;
    c.px          = x[11:0];
    c.py          = y[11:0];
    c.scale       = sc[2:0];
    c.rgb         = rgb;
    c.drain_first = drain;
    char_q.push_back(c);
  endfunction

  task automatic report_bad(input string msg);
    n_bad++;
    if (n_bad <= PRINT_CAP) $display("ERROR: %s", msg);
  endtask

  function automatic void new_burst();
    int r;
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    r = $urandom_range(0, 9);
    if (r < 3) gap_left = 0;
    else if (r < 7) gap_left = $urandom_range(1, 12);
    else if (r < 9) gap_left = $urandom_range(13, 40);
    else gap_left = $urandom_range(41, 90);
  endfunction

  // request side: bursts with gaps, holds data until taken
  always @(posedge clk) begin : drive_requests
    logic offer;
    if (rst) begin
      push <= 1'b0;
      cur_x = 0;
      cur_y = 0;
      new_burst();
    end else begin
      offer = push;
      if (push && !full) begin
        rasterize_char(char_q[0]);
        char_q.delete(0);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_q.size() != 0 &&
                     !(char_q[0].drain_first && row_writes_due.size() != 0)) begin
          offer = 1'b1;
          if (burst_left <= 1) new_burst();
          else burst_left--;
        end
      end
      push <= offer;
      if (char_q.size() != 0) begin
        char_code  <= char_q[0].code;
        set_cursor <= char_q[0].set_cur;
        pos_x      <= char_q[0].px;
        pos_y      <= char_q[0].py;
        scale      <= char_q[0].scale;
        color      <= char_q[0].rgb;
      end
    end
  end

  // result side: check each popped row write, stall in changing modes
  always @(posedge clk) begin : take_row_writes
    logic take;
    row_write_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_rows++;
        if (row_writes_due.size() == 0) begin
          report_bad($sformatf("row write %0d arrived with nothing due", n_rows));
        end else begin
          want = row_writes_due.pop_front();
          if (row !== want.row)
            report_bad($sformatf("write %0d: row %0d, want %0d", n_rows, row, want.row));
          if (x_start !== want.xs)
            report_bad($sformatf("write %0d: x_start %0d, want %0d", n_rows, x_start,
                                 want.xs));
          if (pixel_mask !== want.mask)
            report_bad($sformatf("write %0d: pixel_mask %h, want %h", n_rows, pixel_mask,
                                 want.mask));
          if (pixel_color !== want.rgb)
            report_bad($sformatf("write %0d: pixel_color %h, want %h", n_rows, pixel_color,
                                 want.rgb));
          if (last !== want.last)
            report_bad($sformatf("write %0d: last %b, want %b", n_rows, last, want.last));
        end
        // long hold-off so the command queue backs up and full rises
        if (n_rows == 100 || n_rows == 3000) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 120);
        end else begin
          mode_left--;
        end
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        case (rx_mode)
          RX_ALWAYS:  take = 1'b1;
          RX_MOSTLY:  take = ($urandom_range(0, 3) != 0);
          RX_SPARSE:  take = ($urandom_range(0, 3) == 0);
          default:    take = rx_pattern[0];
        endcase
      end
      pop <= take;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int code, x, y, sc, r;
    logic set_cur;

    // directed: extremes, clamping, clipping, blank glyphs, saturation
    add_char("0", 1'b1, 0, 0, 1, 24'h000000, 1'b0);
    add_char("W", 1'b1, 100, 100, 4, 24'hFFFFFF, 1'b0);
    add_char("A", 1'b0, 0, 0, 0, 24'h123456, 1'b0);        // scale zero
    add_char("B", 1'b0, 0, 0, 5, 24'h00FF00, 1'b0);        // scales above max
    add_char("K", 1'b0, 0, 0, 6, 24'hFF0000, 1'b0);
    add_char("Q", 1'b0, 0, 0, 7, 24'h0000FF, 1'b0);
    add_char(8'hFF, 1'b1, 10, 300, 2, 24'hAAAAAA, 1'b0);   // unsupported codes
    add_char(8'h00, 1'b0, 0, 0, 1, 24'h555555, 1'b0);
    add_char(" ", 1'b0, 0, 0, 3, 24'h0F0F0F, 1'b0);
    add_char("M", 1'b1, -3, 0, 4, 24'hF0F0F0, 1'b0);       // left clip
    add_char("H", 1'b1, 1020, 1020, 4, 24'h808080, 1'b0);  // right and bottom clip
    add_char("E", 1'b1, 40, -5, 2, 24'h7F7F7F, 1'b0);      // top clip
    add_char("8", 1'b1, -2048, -2048, 4, 24'h010203, 1'b0);
    add_char("Z", 1'b1, 2047, 2047, 1, 24'hFEDCBA, 1'b0);
    add_char("j", 1'b1, 2040, 10, 4, 24'h112233, 1'b0);    // cursor saturates
    add_char("X", 1'b0, 5, 5, 1, 24'h445566, 1'b0);
    add_char("%", 1'b1, 1023, 1023, 1, 24'h778899, 1'b0);
    add_char(8'h80, 1'b1, -1, -1, 3, 24'hCCDDEE, 1'b0);
    add_char("g", 1'b1, 500, 1017, 1, 24'h800001, 1'b0);
    add_char(":", 1'b1, 0, 1000, 4, 24'h7FFFFE, 1'b0);
    add_char("f", 1'b1, -20, 512, 4, 24'h00FFFF, 1'b0);    // fully left of the screen
    add_char("!", 1'b1, 1004, 0, 4, 24'hFFFF00, 1'b0);

    for (int k = 0; k < RANDOM_CHARS; k++) begin
      code = ($urandom_range(0, 9) < 8) ? glyph_char($urandom_range(0, GLYPHS-1))
                                        : $urandom_range(0, 255);
      set_cur = ($urandom_range(0, 9) < 3);
      r = $urandom_range(0, 19);
      if (r < 14) begin
        x = $urandom_range(0, 1000);
        y = $urandom_range(0, 1000);
      end else if (r < 17) begin
        x = $urandom_range(0, 1080) - 30;
        y = $urandom_range(0, 1080) - 30;
      end else begin
        x = $urandom_range(0, 4095) - 2048;
        y = $urandom_range(0, 4095) - 2048;
      end
      r = $urandom_range(0, 19);
      if (r == 0) sc = 0;
      else if (r == 1) sc = $urandom_range(5, 7);
      else sc = $urandom_range(1, 4);
      add_char(code[7:0], set_cur, x, y, sc, 24'($urandom()), (k == 0 || k == 200));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || push) @(posedge clk);
    while (row_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (n_bad == 0 && row_writes_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
